// File: design/min_tracking_stack_macros.svh
// Assertion macros shared by the min tracking stack RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MTS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("min_tracking_stack: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define MTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("min_tracking_stack: next-cycle check failed");

`endif

// File: design/mts_pkg.sv
// Shared types and codes for the min tracking stack.
// No dependencies; used by mts_cell and min_tracking_stack.
package mts_pkg;

  localparam int DefaultDepth = 128;
  localparam int DataWidth    = 32;
  localparam int CountOutW    = 8;

  // Command codes
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // One stack entry: value and the minimum at or below it
  typedef struct packed {
    logic signed [DataWidth-1:0] value;
    logic signed [DataWidth-1:0] minimum;
  } entry_t;

  // Shift control broadcast to every cell
  typedef struct packed {
    logic push;  // shift down, away from the top
    logic pop;   // shift up, toward the top
  } shift_ctl_t;

endpackage

// File: design/min_tracking_stack.sv
// Min tracking stack: LIFO of signed words with a running minimum per entry.
// The result is registered into the output register when a transaction is accepted.
// Throughput: one transaction per cycle while out_ready is high; the stack is a
// chain of DEPTH shift cells that all move together on push and pop.
// Reset (rst, synchronous) empties the stack; cell contents are left as is.
// Depends on mts_pkg, mts_cell and min_tracking_stack_macros.svh.
`include "min_tracking_stack_macros.svh"

module min_tracking_stack #(
  parameter int DEPTH = mts_pkg::DefaultDepth
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           command,
  input  logic signed [mts_pkg::DataWidth-1:0] push_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           status,
  output logic signed [mts_pkg::DataWidth-1:0] popped_value,
  output logic signed [mts_pkg::DataWidth-1:0] top_value,
  output logic signed [mts_pkg::DataWidth-1:0] min_value,
  output logic                                 is_empty,
  output logic [mts_pkg::CountOutW-1:0]        entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  // Registers
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  mts_pkg::entry_t cell_q [DEPTH];

  // Combinational step results
  logic                                 accept;
  logic                                 push_ok;
  logic                                 pop_ok;
  mts_pkg::shift_ctl_t                  ctl;
  mts_pkg::entry_t                      new_entry;
  mts_pkg::entry_t                      top_next;
  logic [1:0]                           status_next;
  logic signed [mts_pkg::DataWidth-1:0] popped_next;
  logic [CW+mts_pkg::CountOutW-1:0]     count_wide;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Decode the command against the fill level
  always_comb begin
    push_ok     = 1'b0;
    pop_ok      = 1'b0;
    status_next = mts_pkg::ST_OK;
    case (command)
      mts_pkg::CMD_PUSH: begin
        if (count == FULL) begin
          status_next = mts_pkg::ST_OVERFLOW;
        end else begin
          push_ok = 1'b1;
        end
      end
      mts_pkg::CMD_POP: begin
        if (count == '0) begin
          status_next = mts_pkg::ST_UNDERFLOW;
        end else begin
          pop_ok = 1'b1;
        end
      end
      default: begin
        // peek and the unused code change nothing
      end
    endcase
  end

  assign ctl.push = accept && push_ok;
  assign ctl.pop  = accept && pop_ok;

  // New top entry: its minimum folds in the minimum beneath it
  always_comb begin
    new_entry.value   = push_value;
    new_entry.minimum = push_value;
    if (count != '0 && cell_q[0].minimum < push_value) begin
      new_entry.minimum = cell_q[0].minimum;
    end
  end

  // Cell chain; the bottom cell sees itself from below
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    mts_pkg::entry_t above;
    mts_pkg::entry_t below;
    if (k == 0) begin : g_top
      assign above = new_entry;
    end else begin : g_mid
      assign above = cell_q[k-1];
    end
    if (k == DEPTH - 1) begin : g_bottom
      assign below = cell_q[k];
    end else begin : g_inner
      assign below = cell_q[k+1];
    end
    mts_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_above (above),
      .from_below (below),
      .entry      (cell_q[k])
    );
  end

  // Fill count and the view after the step
  always_comb begin
    count_next  = count;
    top_next    = cell_q[0];
    popped_next = '0;
    if (push_ok) begin
      count_next = count + CW'(1);
      top_next   = new_entry;
    end else if (pop_ok) begin
      count_next  = count - CW'(1);
      top_next    = cell_q[1];
      popped_next = cell_q[0].value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign count_wide = {{mts_pkg::CountOutW{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_next;
      popped_value <= popped_next;
      top_value    <= (count_next == '0) ? '0 : top_next.value;
      min_value    <= (count_next == '0) ? '0 : top_next.minimum;
      is_empty     <= (count_next == '0);
      entry_count  <= count_wide[mts_pkg::CountOutW-1:0];
    end
  end

  // Checks
  `MTS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= FULL)
  `MTS_ASSERT_NEXT(a_result_follows, clk, rst, accept, out_valid)
  `MTS_ASSERT_NEXT(a_push_grows, clk, rst, ctl.push, count == $past(count) + CW'(1))
  `MTS_ASSERT_NEXT(a_push_min, clk, rst, ctl.push, min_value <= $past(push_value))
  `MTS_ASSERT_NOW(a_empty_zero, clk, rst, out_valid && is_empty,
                  top_value == '0 && min_value == '0)

endmodule

// File: design/mts_cell.sv
// One storage cell of the min tracking stack shift chain.
// Depends on mts_pkg for entry_t and shift_ctl_t.
module mts_cell (
  input  logic                clk,
  input  mts_pkg::shift_ctl_t ctl,
  input  mts_pkg::entry_t     from_above,
  input  mts_pkg::entry_t     from_below,
  output mts_pkg::entry_t     entry
);

  mts_pkg::entry_t entry_next;

  // Take the neighbor's entry on a shift, otherwise hold
  always_comb begin
    if (ctl.push) begin
      entry_next = from_above;
    end else if (ctl.pop) begin
      entry_next = from_below;
    end else begin
      entry_next = entry;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
